>>> rtl/vrt_pkg.sv
package vrt_pkg;

    // Walk coordinate: signed, wide enough for the longest walk off the origin
    localparam int CELL_W = 12;

    // Divider operand widths: numerator up to 2^30, divisor up to 2^15
    localparam int DIV_NUM_W = 31;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    // Crossing distances: 16 fraction bits, top bit marks an axis never crossed
    localparam int DIST_W = 32;
    localparam int T_W    = DIST_W + 1;

    // Step-length numerator: one cell with 30 fraction bits
    localparam logic [DIV_NUM_W-1:0] DELTA_NUM = 31'h4000_0000;

    // Register reset values
    localparam logic [15:0] MAX_DIST_RST    = 16'd1280;
    localparam logic [7:0]  PLACE_BLOCK_RST = 8'd1;

    // Register select (paddr bit 2)
    localparam logic REG_MAX_DISTANCE = 1'b0;
    localparam logic REG_PLACE_BLOCK  = 1'b1;

    // Item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    // Hit actions; the fourth code does nothing
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_PLACE  = 2'd2;

    // Division kinds within one axis
    localparam logic DIV_KIND_DELTA = 1'b0;
    localparam logic DIV_KIND_FIRST = 1'b1;

    // Last setup division (axis z, first crossing)
    localparam logic [2:0] DIV_IDX_LAST = 3'd5;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_WALK_INIT,
        ST_STEP,
        ST_READ,
        ST_CHECK,
        ST_ACT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> rtl/vrt_if.sv
// Request channel: write items and ray items
interface vrt_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [11:0]        pos_x;
    logic [15:0]        pos_y;
    logic [11:0]        pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [1:0]         action;
    logic [3:0]         cell_x;
    logic [7:0]         cell_y;
    logic [3:0]         cell_z;
    logic [7:0]         block_code;

    modport source (
        output valid, func, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, action,
               cell_x, cell_y, cell_z, block_code,
        input  ready
    );

    modport sink (
        input  valid, func, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, action,
               cell_x, cell_y, cell_z, block_code,
        output ready
    );
endinterface

// Result channel: one beat per ray item
interface vrt_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  hit_x;
    logic [7:0]  hit_y;
    logic [3:0]  hit_z;
    logic [15:0] hit_distance;
    logic        modified;

    modport source (
        output valid, hit, hit_x, hit_y, hit_z, hit_distance, modified,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_x, hit_y, hit_z, hit_distance, modified,
        output ready
    );
endinterface

>>> rtl/vrt_div.sv
// Restoring divider, one quotient bit per cycle
module vrt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vrt_pkg::div_req_t req,
    output vrt_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [vrt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [vrt_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [vrt_pkg::DIV_DEN_W-1:0] rem_next;
    logic [vrt_pkg::DIV_NUM_W-1:0] quot_reg;
    logic [vrt_pkg::DIV_DEN_W-1:0] den_reg;
    logic [vrt_pkg::DIV_DEN_W:0]   trial;
    logic                          qbit;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quot_reg[vrt_pkg::DIV_NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
        if (qbit)
        begin
            rem_next = vrt_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[vrt_pkg::DIV_DEN_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vrt_pkg::DIV_CNT_W'(vrt_pkg::DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quot_reg <= req.num;
            den_reg  <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[vrt_pkg::DIV_NUM_W-2:0], qbit};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> rtl/vrt_grid.sv
// Voxel store: one write and one registered read port, swept to zero after reset
module vrt_grid #(
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    output logic          clear_busy
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;

    // Clearing sweep, one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port mux
    always_comb
    begin
        if (clr_busy_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = 8'd0;
        end
        else
        begin
            we = wr_en;
            wa = wr_addr;
            wd = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

>>> rtl/voxel_ray_traversal_unit.sv
// Voxel ray traversal unit.
// req (valid/ready) carries write items and ray items; rsp (valid/ready)
// carries one result beat per ray item. Write items give no result.
// Registers over APB: max_distance at 0x0, place_block at 0x4; pready is
// always high, writes take effect at the access cycle.
// A write item is taken and stored at once.
// A ray item first runs six divisions (step length and first crossing per
// axis) on one shared radix-2 divider; a zero direction component skips
// its two divisions. The walk then visits each cell stepped in the states
// step, grid read and test, with an action state on a hit and states to
// set up and finish.
// req.ready is low from ray acceptance until its result enters the output
// register; a stalled result holds there, and the block keeps taking
// write items meanwhile but waits with the next ray result until it drains.
// After reset the grid is swept to zero, all GRID_X*GRID_Y*GRID_Z cells
// (65536 at default size), with req.ready low; APB writes are taken.
module voxel_ray_traversal_unit #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 256,
    parameter int GRID_Z = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    vrt_req_if.sink     req,
    vrt_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = vrt_pkg::CELL_W;
    localparam int TW    = vrt_pkg::T_W;
    localparam int DW    = vrt_pkg::DIST_W;
    localparam logic [CW-2:0] GX_LIM = (CW-1)'(GRID_X);
    localparam logic [CW-2:0] GY_LIM = (CW-1)'(GRID_Y);
    localparam logic [CW-2:0] GZ_LIM = (CW-1)'(GRID_Z);

    function automatic logic [AW-1:0] grid_addr(
        input logic [CW-2:0] x,
        input logic [CW-2:0] y,
        input logic [CW-2:0] z
    );
        grid_addr = AW'((32'(x) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_Z) + 32'(z));
    endfunction

    vrt_pkg::state_t state_reg;
    vrt_pkg::state_t state_next;

    // Configuration
    logic [15:0] max_distance_reg;
    logic [7:0]  place_block_reg;

    // Per-axis walk state
    logic signed [CW-1:0]               cell_reg   [3];
    logic                               neg_reg    [3];
    logic [vrt_pkg::DIV_DEN_W-1:0]      mag_reg    [3];
    logic [7:0]                         frac_reg   [3];
    logic [TW-1:0]                      tnext_reg  [3];
    logic [vrt_pkg::DIV_NUM_W-1:0]      tdelta_reg [3];

    logic [1:0]    action_reg;
    logic [2:0]    div_idx_reg;
    logic [DW-1:0] dist_reg;
    logic          found_reg;
    logic          modified_reg;

    // Output register
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [3:0]  out_hx_reg;
    logic [7:0]  out_hy_reg;
    logic [3:0]  out_hz_reg;
    logic [15:0] out_hd_reg;
    logic        out_mod_reg;

    // Sequencer strobes
    logic req_ready;
    logic load_ray;
    logic wr_item;
    logic div_start;
    logic div_skip;
    logic div_store;
    logic step_en;
    logic check_en;
    logic act_en;
    logic out_load;

    // Load-time axis values
    logic [15:0] dir_raw  [3];
    logic [7:0]  pos_cell [3];
    logic [7:0]  pos_frac [3];

    logic [1:0]                    div_axis;
    logic                          div_kind;
    logic [8:0]                    first_n;
    logic                          axis_zero;
    logic                          all_zero;
    vrt_pkg::div_req_t             div_req;
    vrt_pkg::div_rsp_t             div_rsp;

    logic                          lt01;
    logic                          lt02;
    logic                          lt12;
    logic [1:0]                    sel_axis;
    logic [DW-1:0]                 lim;
    logic                          walk_in_grid;
    logic                          found_now;
    logic [AW-1:0]                 walk_addr;
    logic                          item_in_grid;
    logic [AW-1:0]                 item_addr;

    logic                          grid_wr_en;
    logic [AW-1:0]                 grid_wr_addr;
    logic [7:0]                    grid_wr_data;
    logic [7:0]                    grid_rd_data;
    logic                          grid_clear_busy;
    logic                          act_writes;
    logic [15:0]                   hd_sat;

    // Input unpacking per axis
    always_comb
    begin
        dir_raw[0]  = req.dir_x;
        dir_raw[1]  = req.dir_y;
        dir_raw[2]  = req.dir_z;
        pos_cell[0] = {4'd0, req.pos_x[11:8]};
        pos_cell[1] = req.pos_y[15:8];
        pos_cell[2] = {4'd0, req.pos_z[11:8]};
        pos_frac[0] = req.pos_x[7:0];
        pos_frac[1] = req.pos_y[7:0];
        pos_frac[2] = req.pos_z[7:0];
    end

    // Divider operands for the current setup division
    always_comb
    begin
        div_axis  = div_idx_reg[2:1];
        div_kind  = div_idx_reg[0];
        axis_zero = (mag_reg[div_axis] == '0);
        if (neg_reg[div_axis])
        begin
            first_n = {1'b0, frac_reg[div_axis]};
        end
        else
        begin
            first_n = 9'd256 - {1'b0, frac_reg[div_axis]};
        end
        div_req.start = div_start;
        div_req.den   = mag_reg[div_axis];
        if (div_kind == vrt_pkg::DIV_KIND_DELTA)
        begin
            div_req.num = vrt_pkg::DELTA_NUM;
        end
        else
        begin
            div_req.num = {first_n, 22'd0};
        end
    end

    assign all_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);

    // Nearest crossing: x if strictly nearest, else y if nearer than z, else z
    always_comb
    begin
        lt01 = tnext_reg[0] < tnext_reg[1];
        lt02 = tnext_reg[0] < tnext_reg[2];
        lt12 = tnext_reg[1] < tnext_reg[2];
        if (lt01)
        begin
            sel_axis = lt02 ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Z;
        end
        else
        begin
            sel_axis = lt12 ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
        end
    end

    assign lim = {8'd0, max_distance_reg, 8'd0};

    // Cell test and addresses
    always_comb
    begin
        walk_in_grid = !cell_reg[0][CW-1] && (cell_reg[0][CW-2:0] < GX_LIM)
                    && !cell_reg[1][CW-1] && (cell_reg[1][CW-2:0] < GY_LIM)
                    && !cell_reg[2][CW-1] && (cell_reg[2][CW-2:0] < GZ_LIM);
        walk_addr    = grid_addr(cell_reg[0][CW-2:0], cell_reg[1][CW-2:0],
                                 cell_reg[2][CW-2:0]);
        found_now    = walk_in_grid && (grid_rd_data != 8'd0);
        item_in_grid = ((CW-1)'(req.cell_x) < GX_LIM)
                    && ((CW-1)'(req.cell_y) < GY_LIM)
                    && ((CW-1)'(req.cell_z) < GZ_LIM);
        item_addr    = grid_addr((CW-1)'(req.cell_x), (CW-1)'(req.cell_y),
                                 (CW-1)'(req.cell_z));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrt_pkg::ST_CLEAR:
            begin
                if (!grid_clear_busy)
                begin
                    state_next = vrt_pkg::ST_IDLE;
                end
            end
            vrt_pkg::ST_IDLE:
            begin
                if (req.valid && (req.func == vrt_pkg::FUNC_RAY))
                begin
                    state_next = vrt_pkg::ST_DIV_ISSUE;
                end
            end
            vrt_pkg::ST_DIV_ISSUE:
            begin
                if (!axis_zero)
                begin
                    state_next = vrt_pkg::ST_DIV_WAIT;
                end
                else if (div_idx_reg == vrt_pkg::DIV_IDX_LAST)
                begin
                    state_next = vrt_pkg::ST_WALK_INIT;
                end
            end
            vrt_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_idx_reg == vrt_pkg::DIV_IDX_LAST)
                    begin
                        state_next = vrt_pkg::ST_WALK_INIT;
                    end
                    else
                    begin
                        state_next = vrt_pkg::ST_DIV_ISSUE;
                    end
                end
            end
            vrt_pkg::ST_WALK_INIT:
            begin
                if (all_zero || (max_distance_reg == 16'd0))
                begin
                    state_next = vrt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = vrt_pkg::ST_STEP;
                end
            end
            vrt_pkg::ST_STEP:
            begin
                state_next = vrt_pkg::ST_READ;
            end
            vrt_pkg::ST_READ:
            begin
                state_next = vrt_pkg::ST_CHECK;
            end
            vrt_pkg::ST_CHECK:
            begin
                priority if (found_now)
                begin
                    state_next = vrt_pkg::ST_ACT;
                end
                else if (dist_reg < lim)
                begin
                    state_next = vrt_pkg::ST_STEP;
                end
                else
                begin
                    state_next = vrt_pkg::ST_FINISH;
                end
            end
            vrt_pkg::ST_ACT:
            begin
                state_next = vrt_pkg::ST_FINISH;
            end
            vrt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = vrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        load_ray  = 1'b0;
        wr_item   = 1'b0;
        div_start = 1'b0;
        div_skip  = 1'b0;
        div_store = 1'b0;
        step_en   = 1'b0;
        check_en  = 1'b0;
        act_en    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                load_ray  = req.valid && (req.func == vrt_pkg::FUNC_RAY);
                wr_item   = req.valid && (req.func == vrt_pkg::FUNC_WRITE);
            end
            vrt_pkg::ST_DIV_ISSUE:
            begin
                div_start = !axis_zero;
                div_skip  = axis_zero;
            end
            vrt_pkg::ST_DIV_WAIT:
            begin
                div_store = div_rsp.done;
            end
            vrt_pkg::ST_STEP:
            begin
                step_en = 1'b1;
            end
            vrt_pkg::ST_CHECK:
            begin
                check_en = 1'b1;
            end
            vrt_pkg::ST_ACT:
            begin
                act_en = 1'b1;
            end
            vrt_pkg::ST_FINISH:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // APB registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= vrt_pkg::MAX_DIST_RST;
            place_block_reg  <= vrt_pkg::PLACE_BLOCK_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == vrt_pkg::REG_MAX_DISTANCE)
            begin
                max_distance_reg <= pwdata[15:0];
            end
            else
            begin
                place_block_reg <= pwdata[7:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == vrt_pkg::REG_PLACE_BLOCK) ? {24'd0, place_block_reg}
                                                            : {16'd0, max_distance_reg};

    // Ray datapath
    always_ff @(posedge clk)
    begin
        if (load_ray)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= CW'(pos_cell[i]);
                neg_reg[i]  <= dir_raw[i][15];
                mag_reg[i]  <= dir_raw[i][15] ? 16'(~dir_raw[i] + 16'd1) : dir_raw[i];
                frac_reg[i] <= pos_frac[i];
            end
            action_reg   <= req.action;
            div_idx_reg  <= '0;
            dist_reg     <= '0;
            found_reg    <= 1'b0;
            modified_reg <= 1'b0;
        end

        // Setup divisions: a zero component never crosses
        if (div_skip || div_store)
        begin
            div_idx_reg <= div_idx_reg + 1'b1;
            if (div_kind == vrt_pkg::DIV_KIND_DELTA)
            begin
                tdelta_reg[div_axis] <= div_skip ? '0 : div_rsp.quot;
            end
            else
            begin
                tnext_reg[div_axis] <= div_skip ? {1'b1, {DW{1'b0}}}
                                                : {2'b00, div_rsp.quot};
            end
        end

        // One crossing along the nearest axis
        if (step_en)
        begin
            if (neg_reg[sel_axis])
            begin
                cell_reg[sel_axis] <= cell_reg[sel_axis] - CW'(1);
            end
            else
            begin
                cell_reg[sel_axis] <= cell_reg[sel_axis] + CW'(1);
            end
            dist_reg            <= tnext_reg[sel_axis][DW-1:0];
            tnext_reg[sel_axis] <= tnext_reg[sel_axis] + {2'b00, tdelta_reg[sel_axis]};
        end

        if (check_en && found_now)
        begin
            found_reg <= 1'b1;
        end

        if (act_en)
        begin
            if (action_reg == vrt_pkg::ACT_REMOVE)
            begin
                modified_reg <= 1'b1;
            end
            else if (action_reg == vrt_pkg::ACT_PLACE)
            begin
                modified_reg <= (grid_rd_data != place_block_reg);
            end
        end
    end

    // Grid write port: write items, or the hit action
    always_comb
    begin
        act_writes = (action_reg == vrt_pkg::ACT_REMOVE) || (action_reg == vrt_pkg::ACT_PLACE);
        if (act_en)
        begin
            grid_wr_en   = act_writes;
            grid_wr_addr = walk_addr;
            grid_wr_data = (action_reg == vrt_pkg::ACT_REMOVE) ? 8'd0 : place_block_reg;
        end
        else
        begin
            grid_wr_en   = wr_item && item_in_grid;
            grid_wr_addr = item_addr;
            grid_wr_data = req.block_code;
        end
    end

    vrt_grid #(
        .DEPTH (DEPTH)
    ) u_grid (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (grid_wr_en),
        .wr_addr    (grid_wr_addr),
        .wr_data    (grid_wr_data),
        .rd_addr    (walk_addr),
        .rd_data    (grid_rd_data),
        .clear_busy (grid_clear_busy)
    );

    vrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Reported distance: drop 8 fraction bits, saturate
    assign hd_sat = (dist_reg[DW-1:24] != '0) ? 16'hFFFF : dist_reg[23:8];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg <= found_reg;
            out_hx_reg  <= found_reg ? cell_reg[0][3:0] : 4'd0;
            out_hy_reg  <= found_reg ? cell_reg[1][7:0] : 8'd0;
            out_hz_reg  <= found_reg ? cell_reg[2][3:0] : 4'd0;
            out_hd_reg  <= hd_sat;
            out_mod_reg <= found_reg && modified_reg;
        end
    end

    assign req.ready        = req_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.hit_x        = out_hx_reg;
    assign rsp.hit_y        = out_hy_reg;
    assign rsp.hit_z        = out_hz_reg;
    assign rsp.hit_distance = out_hd_reg;
    assign rsp.modified     = out_mod_reg;

endmodule

>>> rtl/vrt_checker.sv
// Port-level checks for the voxel ray traversal unit
module vrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_func,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [3:0]  rsp_hit_x,
    input logic [7:0]  rsp_hit_y,
    input logic [3:0]  rsp_hit_z,
    input logic [15:0] rsp_hit_distance,
    input logic        rsp_modified
);

    // Stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_hit, rsp_hit_x, rsp_hit_y, rsp_hit_z,
                        rsp_hit_distance, rsp_modified}))
        else $error("result beat changed while stalled");

    // A miss reports no cell and no change
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_hit_x == 4'd0 && rsp_hit_y == 8'd0
            && rsp_hit_z == 4'd0 && !rsp_modified)
        else $error("miss with nonzero cell or modified set");

    // Ray item occupies the block
    a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_func == vrt_pkg::FUNC_RAY |=> !req_ready)
        else $error("ready right after a ray item");

    // Write item leaves the block ready
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_func == vrt_pkg::FUNC_WRITE |=> req_ready)
        else $error("not ready after a write item");

endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_func         (req.func),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_hit          (rsp.hit),
    .rsp_hit_x        (rsp.hit_x),
    .rsp_hit_y        (rsp.hit_y),
    .rsp_hit_z        (rsp.hit_z),
    .rsp_hit_distance (rsp.hit_distance),
    .rsp_modified     (rsp.modified)
);

>>> dv/tb_voxel_ray_traversal_unit.sv
`timescale 1ns / 100ps

module tb_voxel_ray_traversal_unit;

    localparam int GRID_X = 16;
    localparam int GRID_Y = 256;
    localparam int GRID_Z = 16;
    localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_PRINTED_ERRORS = 50;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint unsigned NEVER = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic        func;
        logic [11:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] pos_z;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic [1:0]  action;
        logic [3:0]  cell_x;
        logic [7:0]  cell_y;
        logic [3:0]  cell_z;
        logic [7:0]  block_code;
    } voxel_req_t;

    typedef struct {
        logic        hit;
        logic [3:0]  hit_x;
        logic [7:0]  hit_y;
        logic [3:0]  hit_z;
        logic [15:0] hit_distance;
        logic        modified;
    } ray_hit_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vrt_req_if req_bus ();
    vrt_rsp_if rsp_bus ();

    voxel_ray_traversal_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus.sink),
        .rsp     (rsp_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: grid contents and register copies
    logic [7:0]  grid_model [0:GRID_CELLS-1];
    logic [15:0] max_dist_reg = vrt_pkg::MAX_DIST_RST;
    logic [7:0]  place_reg    = vrt_pkg::PLACE_BLOCK_RST;

    voxel_req_t item_pending [$];
    ray_hit_t   hit_expect [$];
    voxel_req_t cur_req;

    int  req_issued = 0;
    int  req_taken = 0;
    int  send_gap = 0;
    int  rsp_hold = 0;
    int  results_seen = 0;
    int  err_count = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED_ERRORS)
        begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            flag_error($sformatf("result %0d %s = 0x%0h, want 0x%0h",
                                 results_seen, name, got, want));
        end
    endtask

    function automatic int unsigned cell_addr(input int x, input int y, input int z);
        return int'((x * GRID_Y + y) * GRID_Z + z);
    endfunction

    // Walk the grid along one ray; applies the hit action to grid_model
    function automatic ray_hit_t trace_ray(input voxel_req_t it);
        logic [15:0]     pos [3];
        logic [15:0]     dir [3];
        int              cpos [3];
        int              stp [3];
        longint unsigned tnext [3];
        longint unsigned tdelta [3];
        longint unsigned mag, frac, lim, walk_len;
        int              k;
        bit              found;
        int unsigned     addr;
        ray_hit_t        res;

        pos[0] = 16'(it.pos_x);
        pos[1] = it.pos_y;
        pos[2] = 16'(it.pos_z);
        dir[0] = it.dir_x;
        dir[1] = it.dir_y;
        dir[2] = it.dir_z;

        // per-axis step length and first face crossing
        for (int a = 0; a < 3; a++)
        begin
            mag = dir[a][15] ? 64'h1_0000 - 64'(dir[a]) : 64'(dir[a]);
            frac = 64'(pos[a][7:0]);
            cpos[a] = int'(pos[a][15:8]);
            stp[a] = dir[a][15] ? -1 : 1;
            if (mag == 0)
            begin
                tnext[a] = NEVER;
                tdelta[a] = 0;
            end
            else
            begin
                tdelta[a] = (64'd1 << 30) / mag;
                tnext[a] = dir[a][15] ? (frac << 22) / mag
                                      : ((64'd256 - frac) << 22) / mag;
            end
        end

        // step through cells; the crossing past the limit is still tested
        walk_len = 0;
        found = 1'b0;
        lim = 64'(max_dist_reg) << 8;
        if (tnext[0] != NEVER || tnext[1] != NEVER || tnext[2] != NEVER)
        begin
            while (!found && walk_len < lim)
            begin
                if (tnext[0] < tnext[1])
                    k = (tnext[0] < tnext[2]) ? 0 : 2;
                else
                    k = (tnext[1] < tnext[2]) ? 1 : 2;
                cpos[k] += stp[k];
                walk_len = tnext[k];
                tnext[k] += tdelta[k];
                if (cpos[0] >= 0 && cpos[0] < GRID_X && cpos[1] >= 0 && cpos[1] < GRID_Y &&
                    cpos[2] >= 0 && cpos[2] < GRID_Z &&
                    grid_model[cell_addr(cpos[0], cpos[1], cpos[2])] != 8'd0)
                    found = 1'b1;
            end
        end

        res.hit = found;
        res.hit_x = found ? 4'(cpos[0]) : 4'd0;
        res.hit_y = found ? 8'(cpos[1]) : 8'd0;
        res.hit_z = found ? 4'(cpos[2]) : 4'd0;
        res.hit_distance = ((walk_len >> 8) > 64'hFFFF) ? 16'hFFFF : 16'(walk_len >> 8);
        res.modified = 1'b0;

        // hit action
        if (found)
        begin
            addr = cell_addr(cpos[0], cpos[1], cpos[2]);
            if (it.action == vrt_pkg::ACT_REMOVE)
            begin
                grid_model[addr] = 8'd0;
                res.modified = 1'b1;
            end
            else if (it.action == vrt_pkg::ACT_PLACE)
            begin
                res.modified = (grid_model[addr] != place_reg);
                grid_model[addr] = place_reg;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    function automatic int rand_frac();
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
    endfunction

    function automatic logic [15:0] rand_dir();
        int r;
        int m;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 16'd0;
        m = (r < 4) ? 16384 : $urandom_range(1, 16384);
        return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
    endfunction

    function automatic int cell_mid(input int c);
        return c * 256 + 128;
    endfunction

    task automatic push_write(input int x, input int y, input int z, input int code);
        voxel_req_t it;
        it.func = vrt_pkg::FUNC_WRITE;
        it.pos_x = 12'($urandom);
        it.pos_y = 16'($urandom);
        it.pos_z = 12'($urandom);
        it.dir_x = 16'($urandom);
        it.dir_y = 16'($urandom);
        it.dir_z = 16'($urandom);
        it.action = 2'($urandom);
        it.cell_x = 4'(x);
        it.cell_y = 8'(y);
        it.cell_z = 4'(z);
        it.block_code = 8'(code);
        item_pending.push_back(it);
    endtask

    task automatic push_ray(input int px, input int py, input int pz,
                            input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] dz, input logic [1:0] act);
        voxel_req_t it;
        it.func = vrt_pkg::FUNC_RAY;
        it.pos_x = 12'(px);
        it.pos_y = 16'(py);
        it.pos_z = 12'(pz);
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        it.action = act;
        it.cell_x = 4'($urandom);
        it.cell_y = 8'($urandom);
        it.cell_z = 4'($urandom);
        it.block_code = 8'($urandom);
        item_pending.push_back(it);
    endtask

    // Mostly clusters: write 4 to 12 cells of a 4x4x4 cube, then cast rays from inside it
    task automatic queue_random_items(input int count);
        int         made;
        int         x0, y0, z0, n;
        voxel_req_t junk;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                junk.func = 1'($urandom);
                junk.pos_x = 12'($urandom);
                junk.pos_y = 16'($urandom);
                junk.pos_z = 12'($urandom);
                junk.dir_x = 16'($urandom);
                junk.dir_y = 16'($urandom);
                junk.dir_z = 16'($urandom);
                junk.action = 2'($urandom);
                junk.cell_x = 4'($urandom);
                junk.cell_y = 8'($urandom);
                junk.cell_z = 4'($urandom);
                junk.block_code = 8'($urandom);
                item_pending.push_back(junk);
                made++;
            end
            else
            begin
                x0 = $urandom_range(0, GRID_X - 4);
                y0 = $urandom_range(0, GRID_Y - 4);
                z0 = $urandom_range(0, GRID_Z - 4);
                n = $urandom_range(4, 12);
                repeat (n)
                begin
                    push_write(x0 + $urandom_range(0, 3), y0 + $urandom_range(0, 3),
                               z0 + $urandom_range(0, 3),
                               ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255));
                end
                made += n;
                n = $urandom_range(3, 8);
                repeat (n)
                begin
                    push_ray((x0 + $urandom_range(0, 3)) * 256 + rand_frac(),
                             (y0 + $urandom_range(0, 3)) * 256 + rand_frac(),
                             (z0 + $urandom_range(0, 3)) * 256 + rand_frac(),
                             rand_dir(), rand_dir(), rand_dir(), 2'($urandom_range(0, 3)));
                end
                made += n;
            end
        end
    endtask

    // Block until all queued beats are in and every result has come back
    task automatic wait_drained();
        while (item_pending.size() != 0 || req_bus.valid || hit_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB transfer: setup then access; a read is checked at the access edge
    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wr ? data : 32'd0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!wr && prdata !== data)
        begin
            flag_error($sformatf("register %0d reads 0x%0h, want 0x%0h", idx, prdata, data));
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] md, input logic [7:0] pb);
        wait_drained();
        apb_access(1'b1, vrt_pkg::REG_MAX_DISTANCE, {16'($urandom), md});
        apb_access(1'b1, vrt_pkg::REG_PLACE_BLOCK, {24'($urandom), pb});
        max_dist_reg = md;
        place_reg = pb;
        apb_access(1'b0, vrt_pkg::REG_MAX_DISTANCE, {16'd0, md});
        apb_access(1'b0, vrt_pkg::REG_PLACE_BLOCK, {24'd0, pb});
    endtask

    task automatic drive_next();
        voxel_req_t it;
        it = item_pending.pop_front();
        req_bus.func <= it.func;
        req_bus.pos_x <= it.pos_x;
        req_bus.pos_y <= it.pos_y;
        req_bus.pos_z <= it.pos_z;
        req_bus.dir_x <= it.dir_x;
        req_bus.dir_y <= it.dir_y;
        req_bus.dir_z <= it.dir_z;
        req_bus.action <= it.action;
        req_bus.cell_x <= it.cell_x;
        req_bus.cell_y <= it.cell_y;
        req_bus.cell_z <= it.cell_z;
        req_bus.block_code <= it.block_code;
        req_bus.valid <= 1'b1;
        cur_req <= it;
        req_issued++;
    endtask

    // Request driver: one beat at a time, random gaps between beats while gaps_on is set
    always @(negedge clk)
    begin
        if (req_bus.valid && req_taken == req_issued)
        begin
            send_gap = gaps_on ? pick_gap() : 0;
            if (send_gap == 0 && item_pending.size() != 0)
                drive_next();
            else
                req_bus.valid <= 1'b0;
        end
        else if (!req_bus.valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (item_pending.size() != 0)
                drive_next();
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (rsp_hold == 0 && stalls_on)
            rsp_hold = pick_gap();
        if (rsp_hold > 0)
        begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Accepted request beats update the predictor in order
    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            req_taken <= req_taken + 1;
            if (cur_req.func == vrt_pkg::FUNC_WRITE)
                grid_model[cell_addr(cur_req.cell_x, cur_req.cell_y, cur_req.cell_z)] =
                    cur_req.block_code;
            else
                hit_expect.push_back(trace_ray(cur_req));
        end
    end

    // Result checker
    always @(posedge clk)
    begin : rsp_monitor
        ray_hit_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_seen++;
            if (hit_expect.size() == 0)
            begin
                flag_error($sformatf("result %0d arrived with none pending", results_seen));
            end
            else
            begin
                want = hit_expect.pop_front();
                check_field("hit", 16'(rsp_bus.hit), 16'(want.hit));
                check_field("hit_x", 16'(rsp_bus.hit_x), 16'(want.hit_x));
                check_field("hit_y", 16'(rsp_bus.hit_y), 16'(want.hit_y));
                check_field("hit_z", 16'(rsp_bus.hit_z), 16'(want.hit_z));
                check_field("hit_distance", rsp_bus.hit_distance, want.hit_distance);
                check_field("modified", 16'(rsp_bus.modified), 16'(want.modified));
            end
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        logic [1:0] walk_acts [6];

        walk_acts = '{vrt_pkg::ACT_NONE, ACT_UNUSED, vrt_pkg::ACT_PLACE, vrt_pkg::ACT_PLACE,
                      vrt_pkg::ACT_REMOVE, vrt_pkg::ACT_NONE};
        foreach (grid_model[i])
            grid_model[i] = 8'd0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.func = vrt_pkg::FUNC_WRITE;
        req_bus.pos_x = '0;
        req_bus.pos_y = '0;
        req_bus.pos_z = '0;
        req_bus.dir_x = '0;
        req_bus.dir_y = '0;
        req_bus.dir_z = '0;
        req_bus.action = vrt_pkg::ACT_NONE;
        req_bus.cell_x = '0;
        req_bus.cell_y = '0;
        req_bus.cell_z = '0;
        req_bus.block_code = '0;
        rsp_bus.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset register values
        push_ray(cell_mid(3), cell_mid(5), cell_mid(3), 0, 0, 0, vrt_pkg::ACT_PLACE);
        push_write(3, 5, 3, 9);
        push_write(3, 10, 3, 7);
        // origin skipped, then none/unused/place/same-code place/remove/miss
        foreach (walk_acts[i])
            push_ray(cell_mid(3), cell_mid(5), cell_mid(3), 0, 16384, 0, walk_acts[i]);
        push_write(15, 255, 15, 255);
        push_write(0, 0, 0, 200);
        push_write(3, 100, 2, 5);
        push_write(5, 21, 5, 3);
        push_ray(cell_mid(15), cell_mid(254), cell_mid(15), 0, 16384, 0, vrt_pkg::ACT_REMOVE);
        // top corner leaving the grid, three-way tie
        push_ray(12'hFFF, 16'hFFFF, 12'hFFF, 16384, 16384, 16384, vrt_pkg::ACT_NONE);
        // crossings at zero, -32768 and magnitude one
        push_ray(0, 0, 0, -32768, -16384, -1, vrt_pkg::ACT_NONE);
        push_ray(256, 256, 256, -16384, -16384, -16384, vrt_pkg::ACT_REMOVE);
        // far crossing tested past the limit, distance saturates
        push_ray(cell_mid(2), cell_mid(100), cell_mid(2), 1, 0, 0, vrt_pkg::ACT_PLACE);
        // x/y tie goes to y
        push_ray(cell_mid(5), cell_mid(20), cell_mid(5), 16384, 16384, 0, vrt_pkg::ACT_NONE);
        push_ray(cell_mid(7), cell_mid(30), cell_mid(7), 0, 0, 16384, vrt_pkg::ACT_PLACE);
        push_ray(cell_mid(8), cell_mid(40), cell_mid(8), 11585, -11585, 0, ACT_UNUSED);
        queue_random_items(350);

        // zero range: no walk at all
        set_config(16'd0, 8'd255);
        push_ray(cell_mid(5), cell_mid(20), cell_mid(5), 0, 16384, 0, vrt_pkg::ACT_PLACE);
        queue_random_items(40);

        // full range, place code zero clears
        set_config(16'hFFFF, 8'd0);
        push_ray(cell_mid(5), cell_mid(20), cell_mid(5), 0, 16384, 0, vrt_pkg::ACT_PLACE);
        push_ray(cell_mid(8), cell_mid(128), cell_mid(8), 0, 16384, 0, vrt_pkg::ACT_NONE);
        queue_random_items(120);

        // back-to-back stretch, no gaps or stalls
        set_config(16'($urandom_range(256, 3071)), 8'($urandom_range(2, 254)));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        queue_random_items(350);

        set_config(16'd512, 8'($urandom_range(1, 255)));
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        queue_random_items(380);

        // smallest nonzero range: the walk ends at the first crossing at or past the limit
        set_config(16'd1, 8'd128);
        queue_random_items(100);

        wait_drained();
        if (err_count == 0)
            $display("voxel_ray_traversal_unit test passed");
        else
            $display("voxel_ray_traversal_unit test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #150_000_000;
        $display("voxel_ray_traversal_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/vrt_pkg.sv
rtl/vrt_if.sv
rtl/vrt_div.sv
rtl/vrt_grid.sv
rtl/voxel_ray_traversal_unit.sv
rtl/vrt_checker.sv
dv/tb_voxel_ray_traversal_unit.sv
